>>> hdl/peu_pkg.sv
`timescale 1ns / 1ps

package peu_pkg;

    localparam int SLOT_W      = 10;
    localparam int SLOT_EXT_W  = 17;
    localparam int DT_W        = 20;
    localparam int DRAW_W      = 7;
    localparam int WORD_W      = 32;
    localparam int MAX_LIFE_W  = 22;
    localparam int PROD_W      = 53;
    localparam int FRAC_W      = 20;
    localparam int DRAW_RANGE  = 100;
    localparam int FRAC_ONE    = 1048576;
    localparam int IN_DATA_W   = 64;
    localparam int OUT_DATA_W  = 248;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_Z   = 3'd5;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word                  pos_x;
        t_word                  pos_y;
        t_word                  pos_z;
        t_word                  vel_x;
        t_word                  vel_y;
        t_word                  vel_z;
        t_word                  life;
        logic [MAX_LIFE_W-1:0]  max_life;
    } t_particle;

    typedef struct packed {
        logic [SLOT_W-1:0]      slot;
        logic                   oob;
        logic                   resp;
        t_word                  life;
        logic [MAX_LIFE_W-1:0]  max_life;
        t_word                  spawn_vx;
        t_word                  spawn_vy;
        t_word                  spawn_vz;
    } t_meta;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_lane_en;

    typedef logic [DRAW_RANGE-1:0][WORD_W-1:0]     t_vel_tab;
    typedef logic [DRAW_RANGE-1:0][MAX_LIFE_W-1:0] t_life_tab;

    function automatic t_vel_tab f_vel_xz_tab();
        t_vel_tab tab;
        for (int i = 0; i < DRAW_RANGE; i++) begin
            tab[i] = WORD_W'(((i - 50) * FRAC_ONE) / 50);
        end
        return tab;
    endfunction

    function automatic t_vel_tab f_vel_y_tab();
        t_vel_tab tab;
        for (int i = 0; i < DRAW_RANGE; i++) begin
            tab[i] = WORD_W'((i * FRAC_ONE) / 50 + 2 * FRAC_ONE);
        end
        return tab;
    endfunction

    function automatic t_life_tab f_life_tab();
        t_life_tab tab;
        for (int i = 0; i < DRAW_RANGE; i++) begin
            tab[i] = MAX_LIFE_W'((3 * FRAC_ONE) / 2 + (i * FRAC_ONE) / 100);
        end
        return tab;
    endfunction

    localparam t_vel_tab  VEL_XZ_TAB = f_vel_xz_tab();
    localparam t_vel_tab  VEL_Y_TAB  = f_vel_y_tab();
    localparam t_life_tab LIFE_TAB   = f_life_tab();

    // clamp a 33-bit sum to signed 32 bits
    function automatic t_word f_sat33(input logic signed [WORD_W:0] s);
        t_word r;
        if (s[WORD_W] != s[WORD_W-1]) begin
            r = s[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            r = s[WORD_W-1:0];
        end
        return r;
    endfunction

    function automatic t_word f_sat_add(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        return f_sat33(s);
    endfunction

    function automatic logic [DRAW_W-1:0] f_mod100(input logic [DRAW_W-1:0] d);
        logic [DRAW_W-1:0] r;
        r = (d >= DRAW_W'(DRAW_RANGE)) ? d - DRAW_W'(DRAW_RANGE) : d;
        return r;
    endfunction

endpackage

>>> hdl/peu_axis_lane.sv
`timescale 1ns / 1ps

module peu_axis_lane (
    input  logic                          i_clk,
    input  peu_pkg::t_lane_en             i_en,
    input  logic signed [31:0]            i_gravity,
    input  logic [peu_pkg::DT_W-1:0]      i_dt_s1,
    input  logic [peu_pkg::DT_W-1:0]      i_dt_s3,
    input  logic signed [31:0]            i_vel_s1,
    input  logic signed [31:0]            i_pos_s1,
    output logic signed [31:0]            o_vel,
    output logic signed [31:0]            o_pos
);
    import peu_pkg::*;

    logic signed [PROD_W-1:0] r_pg;
    logic signed [PROD_W-1:0] r_pv;
    t_word r_vel_s2, r_pos_s2;
    t_word r_vel_s3, r_pos_s3;
    t_word r_vel_s4, r_pos_s4;

    // gravity*dt, then v += floor(g*dt / 2^20), then new v * dt
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_pg     <= i_gravity * $signed({1'b0, i_dt_s1});
            r_vel_s2 <= i_vel_s1;
            r_pos_s2 <= i_pos_s1;
        end
        if (i_en.s3) begin
            r_vel_s3 <= f_sat_add(r_vel_s2, r_pg[FRAC_W+WORD_W-1:FRAC_W]);
            r_pos_s3 <= r_pos_s2;
        end
        if (i_en.s4) begin
            r_pv     <= r_vel_s3 * $signed({1'b0, i_dt_s3});
            r_vel_s4 <= r_vel_s3;
            r_pos_s4 <= r_pos_s3;
        end
    end

    assign o_vel = r_vel_s4;
    assign o_pos = f_sat_add(r_pos_s4, r_pv[FRAC_W+WORD_W-1:FRAC_W]);

endmodule

>>> hdl/particle_euler_update.sv
`timescale 1ns / 1ps

// Euler update of a stored particle set, one particle per request.
// Slave stream: one request names a slot, a time step and four draws.
// Master stream: one result per request with the particle's new state;
// tuser flags a respawn. Slots at or above PARTICLE_COUNT return all zeros.
// Config channel: register writes (gravity, spawn point), always ready;
// write only while no request is in flight.
// Each accepted request passes stage registers 1 to 4 and the output register.
// Throughput: one request per cycle while no slot hazard, clearing pass or
// receiver stall holds it, set by a five-stage pipeline around one particle
// memory with a registered read port and a write port at the end. A request
// whose slot is still in the pipeline waits until that update is written back.
// Reset: config registers clear to zero and a clearing pass zeroes every
// memory address, during which no request is accepted.
// When the receiver stalls, the output register holds its result and the
// pipeline keeps filling its empty stages before it stops taking requests.

module particle_euler_update #(
    parameter int PARTICLE_COUNT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // slot[9:0], step_time[29:10], draw_x[36:30], draw_y[43:37],
    // draw_z[50:44], draw_life[57:51], zero fill [63:58]
    input  logic [peu_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // out_pos_x[31:0], out_pos_y[63:32], out_pos_z[95:64],
    // out_vel_x[127:96], out_vel_y[159:128], out_vel_z[191:160],
    // out_life[223:192], out_max_life[245:224], zero fill [247:246]
    output logic [peu_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata,
    // respawned[0]
    output logic [0:0]                          o_m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [peu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                         i_cfg_data
);
    import peu_pkg::*;

    localparam int AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

    // config
    t_word r_gravity [3];
    t_word r_spawn   [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_gravity[k] <= '0;
                r_spawn[k]   <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GRAVITY_X: r_gravity[0] <= i_cfg_data;
                CFG_GRAVITY_Y: r_gravity[1] <= i_cfg_data;
                CFG_GRAVITY_Z: r_gravity[2] <= i_cfg_data;
                CFG_SPAWN_X:   r_spawn[0]   <= i_cfg_data;
                CFG_SPAWN_Y:   r_spawn[1]   <= i_cfg_data;
                CFG_SPAWN_Z:   r_spawn[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // input unpack
    logic [SLOT_W-1:0]     w_in_slot;
    logic [SLOT_EXT_W-1:0] w_in_slot_ext;
    logic [DT_W-1:0]       w_in_dt;
    logic [DRAW_W-1:0]     w_in_draw [4];

    assign w_in_slot     = i_s_axis_tdata[9:0];
    assign w_in_slot_ext = {{(SLOT_EXT_W-SLOT_W){1'b0}}, w_in_slot};
    assign w_in_dt       = i_s_axis_tdata[29:10];
    assign w_in_draw[0]  = f_mod100(i_s_axis_tdata[36:30]);
    assign w_in_draw[1]  = f_mod100(i_s_axis_tdata[43:37]);
    assign w_in_draw[2]  = f_mod100(i_s_axis_tdata[50:44]);
    assign w_in_draw[3]  = f_mod100(i_s_axis_tdata[57:51]);

    // pipeline control
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_hazard, w_accept;
    logic r_clr_active;
    logic [AW-1:0] r_clr_addr;

    logic [SLOT_W-1:0]  r_s1_slot;
    logic               r_s1_oob;
    logic [DT_W-1:0]    r_s1_dt, r_s2_dt, r_s3_dt;
    logic [DRAW_W-1:0]  r_s1_draw [4];
    t_particle          r_rd;
    t_meta              r_s2, r_s3, r_s4;

    assign w_rdy5 = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign w_hazard = (r_v1 && r_s1_slot == w_in_slot) ||
                      (r_v2 && r_s2.slot == w_in_slot) ||
                      (r_v3 && r_s3.slot == w_in_slot) ||
                      (r_v4 && r_s4.slot == w_in_slot);

    assign o_s_axis_tready = w_rdy1 && !r_clr_active && !w_hazard;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
            r_v3            <= 1'b0;
            r_v4            <= 1'b0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= w_accept;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) o_m_axis_tvalid <= r_v4;
        end
    end

    // clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == AW'(PARTICLE_COUNT - 1)) begin
                r_clr_active <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // particle memory
    t_particle r_mem [PARTICLE_COUNT];
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_particle     w_wdata;
    t_particle     w_new;
    logic [AW-1:0] w_raddr;

    assign w_raddr = w_in_slot_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_rd <= r_mem[w_raddr];
        end
    end

    // stage 1
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_slot <= w_in_slot;
            r_s1_oob  <= (w_in_slot_ext >= SLOT_EXT_W'(PARTICLE_COUNT));
            r_s1_dt   <= w_in_dt;
            for (int k = 0; k < 4; k++) begin
                r_s1_draw[k] <= w_in_draw[k];
            end
        end
    end

    // stage 2: life test, life update, respawn tables
    logic                  w_s1_resp;
    t_word                 w_s1_life_dec;
    logic [MAX_LIFE_W-1:0] w_s1_life_sp;

    assign w_s1_resp     = !($signed(r_rd.life) > 0);
    assign w_s1_life_dec = f_sat33({r_rd.life[WORD_W-1], r_rd.life} -
                                   {{(WORD_W+1-DT_W){1'b0}}, r_s1_dt});
    assign w_s1_life_sp  = LIFE_TAB[r_s1_draw[3]];

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_s2.slot     <= r_s1_slot;
            r_s2.oob      <= r_s1_oob;
            r_s2.resp     <= w_s1_resp;
            r_s2.life     <= w_s1_resp ? t_word'({{(WORD_W-MAX_LIFE_W){1'b0}}, w_s1_life_sp})
                                       : w_s1_life_dec;
            r_s2.max_life <= w_s1_resp ? w_s1_life_sp : r_rd.max_life;
            r_s2.spawn_vx <= VEL_XZ_TAB[r_s1_draw[0]];
            r_s2.spawn_vy <= VEL_Y_TAB[r_s1_draw[1]];
            r_s2.spawn_vz <= VEL_XZ_TAB[r_s1_draw[2]];
            r_s2_dt       <= r_s1_dt;
        end
        if (w_rdy3) begin
            r_s3    <= r_s2;
            r_s3_dt <= r_s2_dt;
        end
        if (w_rdy4) begin
            r_s4 <= r_s3;
        end
    end

    // per-axis velocity and position datapath
    t_lane_en w_lane_en;
    t_word    w_vel_in [3];
    t_word    w_pos_in [3];
    t_word    w_vel_out [3];
    t_word    w_pos_out [3];

    assign w_lane_en.s2 = w_rdy2;
    assign w_lane_en.s3 = w_rdy3;
    assign w_lane_en.s4 = w_rdy4;
    assign w_vel_in[0]  = r_rd.vel_x;
    assign w_vel_in[1]  = r_rd.vel_y;
    assign w_vel_in[2]  = r_rd.vel_z;
    assign w_pos_in[0]  = r_rd.pos_x;
    assign w_pos_in[1]  = r_rd.pos_y;
    assign w_pos_in[2]  = r_rd.pos_z;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        peu_axis_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (w_lane_en),
            .i_gravity (r_gravity[g]),
            .i_dt_s1   (r_s1_dt),
            .i_dt_s3   (r_s3_dt),
            .i_vel_s1  (w_vel_in[g]),
            .i_pos_s1  (w_pos_in[g]),
            .o_vel     (w_vel_out[g]),
            .o_pos     (w_pos_out[g])
        );
    end

    // stage 5: result select, write back
    always_comb begin
        w_new.life     = r_s4.life;
        w_new.max_life = r_s4.max_life;
        if (r_s4.resp) begin
            w_new.pos_x = r_spawn[0];
            w_new.pos_y = r_spawn[1];
            w_new.pos_z = r_spawn[2];
            w_new.vel_x = r_s4.spawn_vx;
            w_new.vel_y = r_s4.spawn_vy;
            w_new.vel_z = r_s4.spawn_vz;
        end else begin
            w_new.pos_x = w_pos_out[0];
            w_new.pos_y = w_pos_out[1];
            w_new.pos_z = w_pos_out[2];
            w_new.vel_x = w_vel_out[0];
            w_new.vel_y = w_vel_out[1];
            w_new.vel_z = w_vel_out[2];
        end
    end

    always_comb begin
        if (r_clr_active) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_rdy5 && r_v4 && !r_s4.oob;
            w_waddr = AW'({{(SLOT_EXT_W-SLOT_W){1'b0}}, r_s4.slot});
            w_wdata = w_new;
        end
    end

    t_particle r_out;
    logic      r_out_resp;

    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            if (r_s4.oob) begin
                r_out      <= '0;
                r_out_resp <= 1'b0;
            end else begin
                r_out      <= w_new;
                r_out_resp <= r_s4.resp;
            end
        end
    end

    assign o_m_axis_tdata = {2'b00, r_out.max_life, r_out.life,
                             r_out.vel_z, r_out.vel_y, r_out.vel_x,
                             r_out.pos_z, r_out.pos_y, r_out.pos_x};
    assign o_m_axis_tuser = r_out_resp;

endmodule
